FILE: hdl/didpd_pkg.sv
// Shared types, constants and the microcode table of the dual IIR phase event detector.
package didpd_pkg;

  // Default datapath widths
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_OUTPUT_WIDTH   = 40;
  localparam int DEF_COEF_FRAC_BITS = 16;

  // Filter structure: five feedforward taps, four feedback taps
  localparam int FILTER_TAPS = 5;
  localparam int TAP_W       = 3;

  // Configuration registers
  localparam int REG_WIDTH     = 63;
  localparam int THRESH_WIDTH  = 39;
  localparam int NUM_COEF_REGS = 6;
  localparam int CFG_IDX_W     = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] AMP_REG_BASE   = 3'd3;

  // Event codes on the result channel
  localparam int EV_W = 3;
  localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EV_W-1:0] EV_PEAK   = 3'd1;
  localparam logic [EV_W-1:0] EV_FALL   = 3'd2;
  localparam logic [EV_W-1:0] EV_TROUGH = 3'd3;
  localparam logic [EV_W-1:0] EV_RISE   = 3'd4;

  // Microcode addresses
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_WAIT   = 5'd0;
  localparam logic [STEP_W-1:0] ST_FF0    = 5'd1;
  localparam logic [STEP_W-1:0] ST_FF1    = 5'd2;
  localparam logic [STEP_W-1:0] ST_FF2    = 5'd3;
  localparam logic [STEP_W-1:0] ST_FF3    = 5'd4;
  localparam logic [STEP_W-1:0] ST_FF4    = 5'd5;
  localparam logic [STEP_W-1:0] ST_HI1    = 5'd6;
  localparam logic [STEP_W-1:0] ST_HI2    = 5'd7;
  localparam logic [STEP_W-1:0] ST_HI3    = 5'd8;
  localparam logic [STEP_W-1:0] ST_HI4    = 5'd9;
  localparam logic [STEP_W-1:0] ST_LO1    = 5'd10;
  localparam logic [STEP_W-1:0] ST_LO2    = 5'd11;
  localparam logic [STEP_W-1:0] ST_LO3    = 5'd12;
  localparam logic [STEP_W-1:0] ST_LO4    = 5'd13;
  localparam logic [STEP_W-1:0] ST_DRAIN  = 5'd14;
  localparam logic [STEP_W-1:0] ST_STORE  = 5'd15;
  localparam logic [STEP_W-1:0] ST_FINISH = 5'd16;

  typedef enum logic [2:0] {
    UOP_WAIT,
    UOP_MUL_FF,
    UOP_MUL_HI,
    UOP_MUL_LO,
    UOP_NOP,
    UOP_STORE,
    UOP_FINISH
  } uop_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_INPUT,
    HOLD_OUTPUT
  } hold_t;

  typedef enum logic [1:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_PHASE
  } branch_t;

  typedef enum logic {
    BAND_PHASE,
    BAND_AMP
  } band_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_SUB_SHR
  } acc_op_t;

  typedef enum logic [1:0] {
    PH_WAIT_PEAK,
    PH_WAIT_FALL,
    PH_WAIT_TROUGH,
    PH_WAIT_RISE
  } phase_step_t;

  // One control word
  typedef struct packed {
    uop_t               uop;
    logic               acc_load;
    logic [1:0]         creg;
    logic [1:0]         cfield;
    logic [TAP_W-1:0]   tap;
    hold_t              hold;
    branch_t            branch;
    logic [STEP_W-1:0]  target;
  } ucode_t;

  // Control handed from the sequencer to the datapath and detector
  typedef struct packed {
    uop_t             uop;
    logic             acc_load;
    logic [1:0]       creg;
    logic [1:0]       cfield;
    logic [TAP_W-1:0] tap;
    band_t            band;
    logic             go;
  } seq_ctl_t;

  function automatic ucode_t mk_word(input uop_t uop, input logic acc_load,
                                     input logic [1:0] creg, input logic [1:0] cfield,
                                     input logic [TAP_W-1:0] tap);
    ucode_t u;
    u.uop      = uop;
    u.acc_load = acc_load;
    u.creg     = creg;
    u.cfield   = cfield;
    u.tap      = tap;
    u.hold     = HOLD_NONE;
    u.branch   = BR_NEVER;
    u.target   = ST_WAIT;
    return u;
  endfunction

  // Program ROM: feedforward b0..b4, feedback high halves a1..a4, feedback
  // low halves a1..a4, drain, store (loops once for the amplitude band), finish.
  function automatic ucode_t ucode_fetch(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = mk_word(UOP_NOP, 1'b0, 2'd0, 2'd0, 3'd0);
    case (step)
      ST_WAIT: begin
        u.uop  = UOP_WAIT;
        u.hold = HOLD_INPUT;
      end
      ST_FF0:   u = mk_word(UOP_MUL_FF, 1'b1, 2'd0, 2'd0, 3'd0);
      ST_FF1:   u = mk_word(UOP_MUL_FF, 1'b0, 2'd0, 2'd1, 3'd1);
      ST_FF2:   u = mk_word(UOP_MUL_FF, 1'b0, 2'd0, 2'd2, 3'd2);
      ST_FF3:   u = mk_word(UOP_MUL_FF, 1'b0, 2'd1, 2'd0, 3'd3);
      ST_FF4:   u = mk_word(UOP_MUL_FF, 1'b0, 2'd1, 2'd1, 3'd4);
      ST_HI1:   u = mk_word(UOP_MUL_HI, 1'b0, 2'd1, 2'd2, 3'd0);
      ST_HI2:   u = mk_word(UOP_MUL_HI, 1'b0, 2'd2, 2'd0, 3'd1);
      ST_HI3:   u = mk_word(UOP_MUL_HI, 1'b0, 2'd2, 2'd1, 3'd2);
      ST_HI4:   u = mk_word(UOP_MUL_HI, 1'b0, 2'd2, 2'd2, 3'd3);
      ST_LO1:   u = mk_word(UOP_MUL_LO, 1'b0, 2'd1, 2'd2, 3'd0);
      ST_LO2:   u = mk_word(UOP_MUL_LO, 1'b0, 2'd2, 2'd0, 3'd1);
      ST_LO3:   u = mk_word(UOP_MUL_LO, 1'b0, 2'd2, 2'd1, 3'd2);
      ST_LO4:   u = mk_word(UOP_MUL_LO, 1'b0, 2'd2, 2'd2, 3'd3);
      ST_DRAIN: u = mk_word(UOP_NOP, 1'b0, 2'd0, 2'd0, 3'd0);
      ST_STORE: begin
        u.uop    = UOP_STORE;
        u.branch = BR_PHASE;
        u.target = ST_FF0;
      end
      ST_FINISH: begin
        u.uop    = UOP_FINISH;
        u.hold   = HOLD_OUTPUT;
        u.branch = BR_ALWAYS;
        u.target = ST_WAIT;
      end
      default: begin
        u.branch = BR_ALWAYS;
        u.target = ST_WAIT;
      end
    endcase
    return u;
  endfunction

endpackage

FILE: hdl/didpd_sequencer.sv
// Microcode sequencer: step counter, program ROM, holds and conditional jumps.
module didpd_sequencer
  import didpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_busy,
  output seq_ctl_t ctl
);

  logic [STEP_W-1:0] step_r, step_nxt;
  band_t             band_r, band_nxt;
  ucode_t            word;
  logic              stall;
  logic              go;

  assign word = ucode_fetch(step_r);

  // Hold on the wait step until a beat arrives, on finish until the output is free
  always_comb begin
    stall = 1'b0;
    case (word.hold)
      HOLD_INPUT:  stall = !in_valid;
      HOLD_OUTPUT: stall = out_busy;
      default:     stall = 1'b0;
    endcase
  end

  assign go       = !stall;
  assign in_ready = (word.hold == HOLD_INPUT);

  // Next step and band select
  always_comb begin
    step_nxt = step_r;
    band_nxt = band_r;
    if (go) begin
      step_nxt = step_r + 1'b1;
      unique case (word.branch)
        BR_ALWAYS: step_nxt = word.target;
        BR_PHASE: begin
          if (band_r == BAND_PHASE) begin
            step_nxt = word.target;
            band_nxt = BAND_AMP;
          end
        end
        default: step_nxt = step_r + 1'b1;
      endcase
      if (word.uop == UOP_WAIT) begin
        band_nxt = BAND_PHASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
      band_r <= BAND_PHASE;
    end else begin
      step_r <= step_nxt;
      band_r <= band_nxt;
    end
  end

  always_comb begin
    ctl.uop      = word.uop;
    ctl.acc_load = word.acc_load;
    ctl.creg     = word.creg;
    ctl.cfield   = word.cfield;
    ctl.tap      = word.tap;
    ctl.band     = band_r;
    ctl.go       = go;
  end

endmodule

FILE: hdl/didpd_datapath.sv
// Filter datapath: histories, coefficient select, shared multiplier and accumulator.
module didpd_datapath
  import didpd_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int OUTPUT_WIDTH   = DEF_OUTPUT_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  seq_ctl_t                       ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic [REG_WIDTH-1:0]           coef_regs [NUM_COEF_REGS],
  output logic signed [OUTPUT_WIDTH-1:0] pc,
  output logic signed [OUTPUT_WIDTH-1:0] p1,
  output logic signed [OUTPUT_WIDTH-1:0] p2,
  output logic signed [OUTPUT_WIDTH-1:0] ac,
  output logic signed [OUTPUT_WIDTH-1:0] a1,
  output logic signed [OUTPUT_WIDTH-1:0] a2
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int OW  = OUTPUT_WIDTH;
  localparam int FB  = COEF_FRAC_BITS;
  localparam int CW  = COEF_FRAC_BITS + 5;
  localparam int CX  = (3 * CW > REG_WIDTH) ? 3 * CW : REG_WIDTH;
  localparam int HW  = OW - FB;
  localparam int MB0 = (SW > HW) ? SW : HW;
  localparam int MB  = (MB0 > FB + 1) ? MB0 : FB + 1;
  localparam int PW  = CW + MB;
  localparam int AW  = PW + 5;
  localparam int YD  = FILTER_TAPS - 1;

  logic signed [SW-1:0] x_hist_r [FILTER_TAPS];
  logic signed [OW-1:0] yph_r [YD];
  logic signed [OW-1:0] yam_r [YD];
  logic signed [OW-1:0] pc_r, ac_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  acc_op_t              acc_op_r, acc_op_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;

  logic [CFG_IDX_W-1:0] reg_idx;
  logic [CX-1:0]        reg_ext;
  logic signed [CW-1:0] coef;
  logic signed [OW-1:0] y_sel;
  logic signed [MB-1:0] opb;
  logic                 take_in, store, finish;
  logic [AW-OW:0]       acc_top;
  logic signed [OW-1:0] sat;

  assign take_in = ctl.go && (ctl.uop == UOP_WAIT);
  assign store   = ctl.go && (ctl.uop == UOP_STORE);
  assign finish  = ctl.go && (ctl.uop == UOP_FINISH);

  // Coefficient pick from the packed registers of the current band
  assign reg_idx = CFG_IDX_W'(ctl.creg) + ((ctl.band == BAND_AMP) ? AMP_REG_BASE : '0);
  assign reg_ext = CX'(coef_regs[reg_idx]);

  always_comb begin
    case (ctl.cfield)
      2'd0:    coef = reg_ext[0 +: CW];
      2'd1:    coef = reg_ext[CW +: CW];
      default: coef = reg_ext[2 * CW +: CW];
    endcase
  end

  // Multiplier operand: a sample, or the high or low half of a past output
  assign y_sel = (ctl.band == BAND_AMP) ? yam_r[ctl.tap[1:0]] : yph_r[ctl.tap[1:0]];

  always_comb begin
    acc_op_nxt = ACC_NONE;
    opb        = MB'(x_hist_r[ctl.tap]);
    case (ctl.uop)
      UOP_MUL_FF: begin
        opb        = MB'(x_hist_r[ctl.tap]);
        acc_op_nxt = ctl.acc_load ? ACC_LOAD : ACC_ADD;
      end
      UOP_MUL_HI: begin
        opb        = MB'(y_sel >>> FB);
        acc_op_nxt = ACC_SUB;
      end
      UOP_MUL_LO: begin
        opb        = MB'({1'b0, y_sel[FB-1:0]});
        acc_op_nxt = ACC_SUB_SHR;
      end
      default: acc_op_nxt = ACC_NONE;
    endcase
  end

  assign prod_nxt = coef * opb;

  // Accumulate the registered product
  always_comb begin
    case (acc_op_r)
      ACC_LOAD:    acc_nxt = AW'(prod_r);
      ACC_ADD:     acc_nxt = acc_r + AW'(prod_r);
      ACC_SUB:     acc_nxt = acc_r - AW'(prod_r);
      ACC_SUB_SHR: acc_nxt = acc_r - AW'(prod_r >>> FB);
      default:     acc_nxt = acc_r;
    endcase
  end

  // Saturate to the signed output range
  assign acc_top = acc_r[AW-1:OW-1];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      sat = acc_r[OW-1:0];
    end else if (acc_r[AW-1]) begin
      sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OW-1){1'b1}}};
    end
  end

  // Multiplier and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_op_r <= ACC_NONE;
    end else begin
      acc_op_r <= acc_op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (store) begin
      if (ctl.band == BAND_PHASE) begin
        pc_r <= sat;
      end else begin
        ac_r <= sat;
      end
    end
  end

  // Sample and output histories, newest at index 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILTER_TAPS; i++) begin
        x_hist_r[i] <= '0;
      end
      for (int i = 0; i < YD; i++) begin
        yph_r[i] <= '0;
        yam_r[i] <= '0;
      end
    end else begin
      if (take_in) begin
        x_hist_r[0] <= in_sample;
        for (int i = 1; i < FILTER_TAPS; i++) begin
          x_hist_r[i] <= x_hist_r[i-1];
        end
      end
      if (finish) begin
        yph_r[0] <= pc_r;
        yam_r[0] <= ac_r;
        for (int i = 1; i < YD; i++) begin
          yph_r[i] <= yph_r[i-1];
          yam_r[i] <= yam_r[i-1];
        end
      end
    end
  end

  assign pc = pc_r;
  assign p1 = yph_r[0];
  assign p2 = yph_r[1];
  assign ac = ac_r;
  assign a1 = yam_r[0];
  assign a2 = yam_r[1];

endmodule

FILE: hdl/didpd_event_detect.sv
// Extremum and zero-crossing detection, held amplitude, phase cycle and result register.
module didpd_event_detect
  import didpd_pkg::*;
#(
  parameter int OUTPUT_WIDTH = DEF_OUTPUT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  seq_ctl_t                       ctl,
  input  logic [THRESH_WIDTH-1:0]        threshold,
  input  logic signed [OUTPUT_WIDTH-1:0] pc,
  input  logic signed [OUTPUT_WIDTH-1:0] p1,
  input  logic signed [OUTPUT_WIDTH-1:0] p2,
  input  logic signed [OUTPUT_WIDTH-1:0] ac,
  input  logic signed [OUTPUT_WIDTH-1:0] a1,
  input  logic signed [OUTPUT_WIDTH-1:0] a2,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [OUTPUT_WIDTH-1:0]        out_held_amplitude_out,
  output logic [EV_W-1:0]                out_event_res,
  output logic                           out_busy
);

  localparam int OW = OUTPUT_WIDTH;
  localparam int XW = ((OW > THRESH_WIDTH) ? OW : THRESH_WIDTH + 1) + 1;

  phase_step_t          step_r, step_nxt;
  logic [OW-1:0]        held_r, held_nxt;
  logic [EV_W-1:0]      ev_r, ev_nxt;
  logic                 out_valid_r;
  logic                 fire;

  logic signed [XW-1:0] thx, nthx, heldx;
  logic signed [XW-1:0] pcx, p1x, p2x, acx, a1x, a2x;
  logic                 held_ok;

  assign fire = ctl.go && (ctl.uop == UOP_FINISH);

  // Compare everything in one widened signed domain
  assign thx   = XW'(threshold);
  assign nthx  = -thx;
  assign pcx   = XW'(pc);
  assign p1x   = XW'(p1);
  assign p2x   = XW'(p2);
  assign acx   = XW'(ac);
  assign a1x   = XW'(a1);
  assign a2x   = XW'(a2);

  // Amplitude band: local max above +th or local min below -th
  always_comb begin
    held_nxt = held_r;
    if ((a1x > a2x) && (a1x > acx) && (a1x > thx)) begin
      held_nxt = a1;
    end else if ((a1x < a2x) && (a1x < acx) && (a1x < nthx)) begin
      held_nxt = -a1;
    end
  end

  assign heldx   = XW'(held_nxt);
  assign held_ok = (heldx > thx);

  // Phase cycle: peak, falling zero, trough, rising zero
  always_comb begin
    step_nxt = step_r;
    ev_nxt   = EV_NONE;
    unique case (step_r)
      PH_WAIT_PEAK: begin
        if ((p1x > p2x) && (p1x > pcx) && held_ok) begin
          step_nxt = PH_WAIT_FALL;
          ev_nxt   = EV_PEAK;
        end
      end
      PH_WAIT_FALL: begin
        if (pc[OW-1] && !p1[OW-1] && (|p1)) begin
          step_nxt = PH_WAIT_TROUGH;
          ev_nxt   = EV_FALL;
        end
      end
      PH_WAIT_TROUGH: begin
        if ((p1x < p2x) && (p1x < pcx) && held_ok) begin
          step_nxt = PH_WAIT_RISE;
          ev_nxt   = EV_TROUGH;
        end
      end
      PH_WAIT_RISE: begin
        if (!pc[OW-1] && (|pc) && p1[OW-1]) begin
          step_nxt = PH_WAIT_PEAK;
          ev_nxt   = EV_RISE;
        end
      end
      default: begin
        step_nxt = PH_WAIT_PEAK;
        ev_nxt   = EV_NONE;
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= PH_WAIT_PEAK;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        step_r      <= step_nxt;
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ev_r <= ev_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_held_amplitude_out = held_r;
  assign out_event_res          = ev_r;
  assign out_busy               = out_valid_r && !out_ready;

endmodule

FILE: hdl/dual_iir_phase_event_detector_unit.sv
// Top level of the dual IIR phase event detector: configuration registers and block wiring.
//
// Each accepted sample runs through a phase-band and an amplitude-band IIR filter
// (b0..b4, a1..a4, signed Q5.16 coefficients, saturating Q24.16 outputs) that share
// one sample history; every sample gives exactly one result beat carrying the held
// amplitude and the phase event (none, peak, falling zero, trough, rising zero).
// A sample is accepted only once the previous one has finished all of its steps: one shared
// multiplier, driven by a microcoded step sequence, does 13 products per band (five
// feedforward terms and the high and low halves of four feedback terms) for both bands in
// turn. The result is registered at the finish step. A new sample is taken while the
// previous result still waits on the output register.
// Coefficient registers 0..5 and the threshold (register 6) reset to zero and
// should be written while the block is idle; writes to index 7 are ignored.
module dual_iir_phase_event_detector_unit
  import didpd_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int OUTPUT_WIDTH   = DEF_OUTPUT_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [OUTPUT_WIDTH-1:0]        out_held_amplitude_out,
  output logic [EV_W-1:0]                out_event_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [REG_WIDTH-1:0]           cfg_data
);

  logic [REG_WIDTH-1:0]    coef_r [NUM_COEF_REGS];
  logic [THRESH_WIDTH-1:0] thresh_r;

  seq_ctl_t                       ctl;
  logic                           out_busy;
  logic signed [OUTPUT_WIDTH-1:0] pc, p1, p2, ac, a1, a2;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF_REGS; i++) begin
        coef_r[i] <= '0;
      end
      thresh_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index < CFG_IDX_THRESH) begin
        coef_r[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_IDX_THRESH) begin
        thresh_r <= cfg_data[THRESH_WIDTH-1:0];
      end
    end
  end

  didpd_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  didpd_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .OUTPUT_WIDTH   (OUTPUT_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_sample (in_sample),
    .coef_regs (coef_r),
    .pc        (pc),
    .p1        (p1),
    .p2        (p2),
    .ac        (ac),
    .a1        (a1),
    .a2        (a2)
  );

  didpd_event_detect #(
    .OUTPUT_WIDTH (OUTPUT_WIDTH)
  ) u_det (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctl                    (ctl),
    .threshold              (thresh_r),
    .pc                     (pc),
    .p1                     (p1),
    .p2                     (p2),
    .ac                     (ac),
    .a1                     (a1),
    .a2                     (a2),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .out_held_amplitude_out (out_held_amplitude_out),
    .out_event_res          (out_event_res),
    .out_busy               (out_busy)
  );

endmodule
